FILE: rtl/zrg_pkg.sv
// shared types and constants of the zone request generator
package zrg_pkg;

    localparam int ZONE_W   = 6;
    localparam int TEMP_W   = 16;
    localparam int PCT_W    = 10;
    localparam int FLOW_W   = 16;
    localparam int TIME_W   = 16;
    localparam int REQ_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMPERIAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_PERSIST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_PERSIST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS = 2'd3;

    localparam logic [TIME_W-1:0] RST_PRESS_PERSIST = 16'd600;
    localparam logic [TIME_W-1:0] RST_TEMP_PERSIST  = 16'd1200;
    localparam logic [TIME_W-1:0] RST_SUPPRESS      = 16'd600;

    localparam logic [PCT_W-1:0] LEVEL_ON  = 10'd950;
    localparam logic [PCT_W-1:0] LEVEL_OFF = 10'd850;

    localparam logic signed [TEMP_W:0] HIGH_DIFF_SI = 17'sd300;
    localparam logic signed [TEMP_W:0] MED_DIFF_SI  = 17'sd200;
    localparam logic signed [TEMP_W:0] HIGH_DIFF_IP = 17'sd500;
    localparam logic signed [TEMP_W:0] MED_DIFF_IP  = 17'sd300;

    localparam logic [REQ_W-1:0] REQ_NONE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ONE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TWO  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_THREE = 2'd3;

    typedef struct packed {
        logic [ZONE_W-1:0]        zone_index;
        logic signed [TEMP_W-1:0] zone_temp;
        logic signed [TEMP_W-1:0] cooling_setpoint;
        logic [PCT_W-1:0]         cooling_demand;
        logic [FLOW_W-1:0]        airflow;
        logic [FLOW_W-1:0]        airflow_setpoint;
        logic [PCT_W-1:0]         damper_command;
        logic [TIME_W-1:0]        elapsed_time;
    } t_sample;

    typedef struct packed {
        logic [ZONE_W-1:0] result_zone;
        logic [REQ_W-1:0]  pressure_request;
        logic [REQ_W-1:0]  cooling_request;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [1:0] count;
    } t_queue_status;

endpackage

FILE: rtl/zrg_stream_if.sv
// valid/ready stream channel carrying one payload beat
interface zrg_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/zrg_result_queue.sv
// three-entry result queue between the update stage and the output channel
module zrg_result_queue
    import zrg_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_result       i_data,
    input  logic          i_ready,
    output t_queue_status o_status,
    output t_result       o_data
);

    localparam logic [1:0] LAST = 2'd2;

    t_result    r_buf [3];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign pop = (r_count != 2'd0) && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? 2'd0 : r_wr_ptr + 2'd1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? 2'd0 : r_rd_ptr + 2'd1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_buf[r_rd_ptr];
    assign o_status.valid = (r_count != 2'd0);
    assign o_status.count = r_count;

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd3) || i_ready)
        else $error("result queue overflow");
`endif

endmodule

FILE: rtl/zone_request_generator_unit.sv
// zone request generator top level: per-zone timer store and request logic
// a sample beat is registered in the input stage, then its result beat is pushed into the result queue
// throughput: one sample per cycle while the result queue has room, set by the single
//   read-modify-write memory port with a one-deep write-back forward for back-to-back
//   samples of the same zone; reset: synchronous active-low, then a clearing pass
//   zeroes the zone store with sample ready low; configuration writes are taken meanwhile
module zone_request_generator_unit
    import zrg_pkg::*;
#(
    parameter int NUM_ZONES  = 64,
    parameter int TIMER_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    zrg_stream_if.sink            i_sample,
    zrg_stream_if.source          o_result
);

    localparam int AW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
    localparam int TB = TIMER_BITS;
    localparam int SW = ((TB > TIME_W) ? TB : TIME_W) + 1;
    localparam logic [SW-1:0] TMAX_EXT = SW'({TB{1'b1}});
    localparam logic [AW-1:0] LAST_ZONE = AW'(NUM_ZONES - 1);

    typedef struct packed {
        logic [TB-1:0] ph;
        logic [TB-1:0] pm;
        logic [TB-1:0] th;
        logic [TB-1:0] tm;
        logic [TB-1:0] st;
        logic [1:0]    pl;
        logic [1:0]    tl;
    } t_entry;

    typedef struct packed {
        logic [ZONE_W-1:0] zone;
        logic [AW-1:0]     addr;
        logic              in_range;
        logic [TIME_W-1:0] dt;
        logic              sp_zero;
        logic              near_open;
        logic              damp_off;
        logic              lo50;
        logic              lo70;
        logic              ge_high;
        logic              ge_med;
        logic              dem_on;
        logic              dem_off;
    } t_stage;

    function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] t,
                                              input logic [TIME_W-1:0] dt);
        logic [SW-1:0] s;
        s = SW'(t) + SW'(dt);
        if (s > TMAX_EXT) begin
            sat_add = {TB{1'b1}};
        end else begin
            sat_add = s[TB-1:0];
        end
    endfunction

    function automatic logic reached(input logic [TB-1:0] t,
                                     input logic [TIME_W-1:0] lim);
        reached = SW'(t) >= SW'(lim);
    endfunction

    // configuration registers
    logic              r_imperial;
    logic [TIME_W-1:0] r_press_persist;
    logic [TIME_W-1:0] r_temp_persist;
    logic [TIME_W-1:0] r_suppress;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imperial      <= 1'b0;
            r_press_persist <= RST_PRESS_PERSIST;
            r_temp_persist  <= RST_TEMP_PERSIST;
            r_suppress      <= RST_SUPPRESS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMPERIAL:      r_imperial      <= i_cfg_data[0];
                REG_PRESS_PERSIST: r_press_persist <= i_cfg_data;
                REG_TEMP_PERSIST:  r_temp_persist  <= i_cfg_data;
                REG_SUPPRESS:      r_suppress      <= i_cfg_data;
                default:           r_imperial      <= r_imperial;
            endcase
        end
    end

    // clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ZONE) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // input stage: decode the sample into flags
    t_queue_status q_status;
    logic          accept;
    t_stage        n_s1;
    t_stage        r_s1;
    logic          r_s1_valid;
    t_sample       smp;
    logic signed [TEMP_W:0] excess;
    logic signed [TEMP_W:0] high_diff;
    logic signed [TEMP_W:0] med_diff;

    assign i_sample.ready = !r_clr_busy &&
        ({1'b0, q_status.count} + {2'b00, r_s1_valid} <= 3'd2);
    assign accept = i_sample.valid && i_sample.ready;
    assign smp    = i_sample.data;

    always_comb begin
        excess    = {smp.zone_temp[TEMP_W-1], smp.zone_temp}
                  - {smp.cooling_setpoint[TEMP_W-1], smp.cooling_setpoint};
        high_diff = r_imperial ? HIGH_DIFF_IP : HIGH_DIFF_SI;
        med_diff  = r_imperial ? MED_DIFF_IP : MED_DIFF_SI;
        n_s1.zone      = smp.zone_index;
        n_s1.addr      = AW'(smp.zone_index);
        n_s1.in_range  = 32'(smp.zone_index) < NUM_ZONES;
        n_s1.dt        = smp.elapsed_time;
        n_s1.sp_zero   = (smp.airflow_setpoint == '0);
        n_s1.near_open = smp.damper_command >= LEVEL_ON;
        n_s1.damp_off  = smp.damper_command >= LEVEL_OFF;
        n_s1.lo50      = {smp.airflow, 1'b0} < {1'b0, smp.airflow_setpoint};
        n_s1.lo70      = (20'(smp.airflow) * 20'd10) < (20'(smp.airflow_setpoint) * 20'd7);
        n_s1.ge_high   = excess >= high_diff;
        n_s1.ge_med    = excess >= med_diff;
        n_s1.dem_on    = smp.cooling_demand >= LEVEL_ON;
        n_s1.dem_off   = smp.cooling_demand >= LEVEL_OFF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // zone store
    t_entry        r_mem [NUM_ZONES];
    t_entry        r_rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          item_wr;
    t_entry        upd;

    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = item_wr;
            wr_addr = r_s1.addr;
            wr_data = upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[n_s1.addr];
    end

    // forward of the write made at the previous edge
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    t_entry        r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= item_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= r_s1.addr;
        r_fwd_data <= upd;
    end

    // update stage
    t_entry            cur;
    t_result           res;
    logic [TB-1:0]     ph_sum, pm_sum, th_sum, tm_sum, st_sum;
    logic              temp_active;
    logic [REQ_W-1:0]  p_req, c_req;

    assign item_wr = r_s1_valid && r_s1.in_range && !r_clr_busy;

    always_comb begin
        cur = (r_fwd_valid && r_fwd_addr == r_s1.addr) ? r_fwd_data : r_rd_data;
        ph_sum = sat_add(cur.ph, r_s1.dt);
        pm_sum = sat_add(cur.pm, r_s1.dt);
        th_sum = sat_add(cur.th, r_s1.dt);
        tm_sum = sat_add(cur.tm, r_s1.dt);
        st_sum = sat_add(cur.st, r_s1.dt);
        upd = cur;

        // pressure requests
        if (r_s1.sp_zero) begin
            upd.ph = '0;
            upd.pm = '0;
            p_req  = REQ_NONE;
        end else begin
            upd.ph = (r_s1.near_open && r_s1.lo50) ? ph_sum : '0;
            upd.pm = (r_s1.near_open && r_s1.lo70) ? pm_sum : '0;
            if (reached(upd.ph, r_press_persist)) begin
                upd.pm = '0;
                p_req  = REQ_THREE;
            end else if (reached(upd.pm, r_press_persist)) begin
                p_req = REQ_TWO;
            end else if (r_s1.near_open) begin
                p_req = REQ_ONE;
            end else if (cur.pl == REQ_ONE && r_s1.damp_off) begin
                p_req = REQ_ONE;
            end else begin
                p_req = REQ_NONE;
            end
        end
        upd.pl = p_req;

        // suppression and cooling requests
        if (SW'(cur.st) < SW'(r_suppress)) begin
            upd.st = (SW'(st_sum) > SW'(r_suppress)) ? TB'(r_suppress) : st_sum;
        end
        temp_active = SW'(upd.st) >= SW'(r_suppress);
        upd.th = '0;
        upd.tm = '0;
        c_req  = REQ_NONE;
        if (temp_active) begin
            if (r_s1.ge_high) begin
                upd.th = th_sum;
            end else if (r_s1.ge_med) begin
                upd.tm = tm_sum;
            end
        end
        if (temp_active && reached(upd.th, r_temp_persist)) begin
            c_req = REQ_THREE;
        end else if (temp_active && reached(upd.tm, r_temp_persist)) begin
            c_req = REQ_TWO;
        end else if (r_s1.dem_on) begin
            c_req = REQ_ONE;
        end else if (cur.tl == REQ_ONE && r_s1.dem_off) begin
            c_req = REQ_ONE;
        end
        upd.tl = c_req;

        res.result_zone      = r_s1.zone;
        res.pressure_request = r_s1.in_range ? p_req : REQ_NONE;
        res.cooling_request  = r_s1.in_range ? c_req : REQ_NONE;
    end

    // output queue
    zrg_result_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (r_s1_valid),
        .i_data   (res),
        .i_ready  (o_result.ready),
        .o_status (q_status),
        .o_data   (o_result.data)
    );

    assign o_result.valid = q_status.valid;

`ifndef NO_ASSERTIONS
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, q_status.count} + {2'b00, r_s1_valid}) <= 3'd3)
        else $error("items in flight exceed queue room");

    a_clear_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> $past(r_clr_addr) == LAST_ZONE)
        else $error("clearing pass ended early");

    a_sp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1.sp_zero |-> res.pressure_request == REQ_NONE)
        else $error("pressure request with invalid flow setpoint");

    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_valid |-> $past(r_s1_valid) && !$past(r_clr_busy))
        else $error("forward without a sample write");
`endif

endmodule
